/* hw/rtl/asfm_pkg.sv */
// Package for the adaptive symbol frequency model: types, codes and constants.
package asfm_pkg;

    // Fixed sizes set by the field widths.
    localparam int MAX_SYMBOLS  = 2048;
    localparam int SYM_BITS     = 11;
    localparam int ALPHA_BITS   = 12;
    localparam int DEC_DEPTH    = 514;
    localparam int DEC_BITS     = 10;
    localparam int CYC_BITS     = 15;
    localparam int TOTAL_BITS   = 32;

    // Shared table memory: cumulative entries first, decoder entries above them.
    localparam int TAB_DEPTH    = MAX_SYMBOLS + DEC_DEPTH;
    localparam int TAB_BITS     = 12;

    // Defaults for the top-level parameters.
    localparam int DEF_LENGTH_SHIFT = 15;
    localparam int DEF_MAX_TOTAL    = 32768;
    localparam int DEF_COUNT_BITS   = 16;

    // Item operations.
    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_OBSERVE    = 3'd2,
        OP_READ_DIST  = 3'd3,
        OP_READ_TABLE = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ALPHABET = 2'd0,
        CFG_ENCODER  = 2'd1
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_INIT,
        S_ADD,
        S_HRD,
        S_HWR,
        S_DIVST,
        S_DIVW,
        S_CRD,
        S_CMUL,
        S_CWR,
        S_TFILL,
        S_TAIL0,
        S_TAIL,
        S_CYC,
        S_OBS,
        S_RDCUM,
        S_RDDEC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] entry_index;
        logic [15:0] load_value;
        logic        last_load;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  status;
        logic        rebuilt;
    } result_t;

    // Smallest index width of at least 3 with n <= 1 << (width + 2).
    function automatic logic [3:0] dec_index_bits(input logic [ALPHA_BITS-1:0] n);
        logic [3:0] tb;
        tb = 4'd3;
        for (int i = 0; i < 7; i++) begin
            if (n > (ALPHA_BITS'(1) << (tb + 4'd2))) begin
                tb = tb + 4'd1;
            end
        end
        return tb;
    endfunction

endpackage

/* hw/rtl/asfm_div.sv */
// Bit-serial restoring divider that forms 0x80000000 / divisor.
module asfm_div
    import asfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TOTAL_BITS-1:0] divisor,
    output logic                  done,
    output logic [TOTAL_BITS-1:0] quotient
);

    logic [TOTAL_BITS:0]   rem_reg, rem_next;
    logic [TOTAL_BITS-1:0] quo_reg, quo_next;
    logic [TOTAL_BITS-1:0] dvd_reg, dvd_next;
    logic [TOTAL_BITS-1:0] dvs_reg, dvs_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [TOTAL_BITS:0]   trial;

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[TOTAL_BITS-1:0], dvd_reg[TOTAL_BITS-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = '0;
            dvd_next  = 32'h8000_0000;
            dvs_next  = (divisor == '0) ? TOTAL_BITS'(1) : divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[TOTAL_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(TOTAL_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/adaptive_symbol_frequency_model.sv */
// Top level of the adaptive symbol frequency model for an arithmetic coder.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   item     | item_valid / item_stall| item (op, entry_index, load_value,
//            |                        | last_load)
//   result   | result_valid /         | result (read_data, status, rebuilt)
//            | result_stall           |
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item is worked on at a time. An observe that ends the update countdown,
// a last load or an init starts a rebuild. A rebuild halves the counts when
// the total would pass the maximum, runs the serial divider, then makes a
// cumulative pass through the count memory that also fills the decoder table
// when it is used. Init first sets the counts of the alphabet to one.
// After reset a clearing pass sets all 2048 counts to one while
// item_stall is high. A held result does not block the next item's accept.
module adaptive_symbol_frequency_model
    import asfm_pkg::*;
#(
    parameter int LENGTH_SHIFT = DEF_LENGTH_SHIFT,
    parameter int MAX_TOTAL    = DEF_MAX_TOTAL,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [11:0]      cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int DSHIFT = 31 - LENGTH_SHIFT;

    // Memories: counts, and one table memory for cumulative and decoder entries.
    logic [COUNT_BITS-1:0] cnt_mem [MAX_SYMBOLS];
    logic [15:0]           tab_mem [TAB_DEPTH];

    logic                  cnt_we;
    logic [SYM_BITS-1:0]   cnt_wa, cnt_ra;
    logic [COUNT_BITS-1:0] cnt_wd, cnt_q_reg;
    logic                  cum_we;
    logic [15:0]           cum_wd;
    logic                  dec_we;
    logic [DEC_BITS-1:0]   dec_wa;
    logic [SYM_BITS-1:0]   dec_wd;
    logic                  tab_we;
    logic [TAB_BITS-1:0]   tab_wa, tab_ra;
    logic [15:0]           tab_wd, tab_q_reg;

    // Control and datapath registers.
    state_t                state_reg, state_next;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic                  enc_reg;
    item_t                 item_reg, item_next;
    logic [ALPHA_BITS-1:0] k_reg, k_next;
    logic [DEC_BITS-1:0]   s_reg, s_next;
    logic [DEC_BITS-1:0]   w_reg, w_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [TOTAL_BITS-1:0] sum_reg, sum_next;
    logic [TOTAL_BITS-1:0] scale_reg, scale_next;
    logic [TOTAL_BITS-1:0] prod_reg, prod_next;
    logic [CYC_BITS-1:0]   cycle_reg, cycle_next;
    logic [CYC_BITS-1:0]   cdown_reg, cdown_next;
    logic                  init_reg, init_next;
    logic [15:0]           data_reg, data_next;
    logic [1:0]            status_reg, status_next;
    logic                  rb_reg, rb_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    // Derived values.
    logic [ALPHA_BITS-1:0] n;
    logic [ALPHA_BITS-1:0] n_last;
    logic [3:0]            tb;
    logic [DEC_BITS-1:0]   tsize;
    logic                  use_table;
    logic [TOTAL_BITS-1:0] add_total;
    logic [COUNT_BITS:0]   half;
    logic [TOTAL_BITS-1:0] d_full;
    logic [TOTAL_BITS-1:0] d_shift;
    logic [17:0]           cyc5;
    logic [CYC_BITS-1:0]   cyc_cap;
    logic                  div_start, div_done;
    logic [TOTAL_BITS-1:0] div_q;
    logic                  idx_bad;
    logic                  last_k;

    // Effective alphabet size and decoder table geometry.
    always_comb
    begin
        if (alpha_reg < ALPHA_BITS'(2)) begin
            n = ALPHA_BITS'(2);
        end else if (alpha_reg > ALPHA_BITS'(MAX_SYMBOLS)) begin
            n = ALPHA_BITS'(MAX_SYMBOLS);
        end else begin
            n = alpha_reg;
        end
    end

    assign n_last    = n - ALPHA_BITS'(1);
    assign tb        = dec_index_bits(n);
    assign tsize     = DEC_BITS'(1) << tb;
    assign use_table = !enc_reg && (n > ALPHA_BITS'(16));
    assign last_k    = (k_reg == n_last);

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            alpha_reg <= ALPHA_BITS'(2);
            enc_reg   <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ALPHABET: alpha_reg <= cfg_data;
                CFG_ENCODER:  enc_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Count memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_q_reg <= cnt_mem[cnt_ra];
    end

    // Table memory ports; cumulative and decoder writes never share a cycle.
    assign tab_we = cum_we || dec_we;
    assign tab_wa = cum_we ? TAB_BITS'(k_reg[SYM_BITS-1:0])
                           : TAB_BITS'(MAX_SYMBOLS) + TAB_BITS'(dec_wa);
    assign tab_wd = cum_we ? cum_wd : 16'(dec_wd);
    assign tab_ra = (item.op == OP_READ_TABLE)
                  ? TAB_BITS'(MAX_SYMBOLS) + TAB_BITS'(item.entry_index[DEC_BITS-1:0])
                  : TAB_BITS'(item.entry_index);

    always_ff @(posedge clk)
    begin
        if (tab_we) begin
            tab_mem[tab_wa] <= tab_wd;
        end
        tab_q_reg <= tab_mem[tab_ra];
    end

    asfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Intermediate arithmetic.
    assign add_total = total_reg + TOTAL_BITS'(cycle_reg);
    assign half      = ({1'b0, cnt_q_reg} + (COUNT_BITS+1)'(1)) >> 1;
    assign d_full    = prod_reg >> DSHIFT;
    assign d_shift   = d_full >> (5'(LENGTH_SHIFT) - 5'(tb));
    assign cyc5      = (18'(cycle_reg) * 18'd5) >> 2;
    assign cyc_cap   = CYC_BITS'({n + ALPHA_BITS'(6), 3'b000});

    // Range check of the incoming item.
    always_comb
    begin
        idx_bad = 1'b0;
        case (item.op)
            OP_LOAD, OP_OBSERVE, OP_READ_DIST:
                idx_bad = ({1'b0, item.entry_index} >= n);
            OP_READ_TABLE:
                idx_bad = !use_table ||
                          ({1'b0, item.entry_index} >
                           ALPHA_BITS'(tsize) + ALPHA_BITS'(1));
            default:
                idx_bad = 1'b0;
        endcase
    end

    // Sequencer: next state, memory accesses and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        total_next     = total_reg;
        sum_next       = sum_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        cycle_next     = cycle_reg;
        cdown_next     = cdown_reg;
        init_next      = init_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        rb_next        = rb_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        item_stall     = 1'b1;
        cnt_we         = 1'b0;
        cnt_wa         = k_reg[SYM_BITS-1:0];
        cnt_wd         = COUNT_BITS'(1);
        cnt_ra         = k_reg[SYM_BITS-1:0];
        cum_we         = 1'b0;
        cum_wd         = d_full[15:0];
        dec_we         = 1'b0;
        dec_wa         = s_reg + DEC_BITS'(1);
        dec_wd         = k_reg[SYM_BITS-1:0] - SYM_BITS'(1);
        div_start      = 1'b0;

        case (state_reg)
            // Set every count to one after reset.
            S_CLEAR:
            begin
                cnt_we = 1'b1;
                k_next = k_reg + ALPHA_BITS'(1);
                if (k_reg == ALPHA_BITS'(MAX_SYMBOLS - 1)) begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end
            end

            // Take an item and start its memory access.
            S_IDLE:
            begin
                item_stall  = 1'b0;
                cnt_ra      = item.entry_index;
                if (item_valid) begin
                    item_next   = item;
                    data_next   = '0;
                    status_next = ST_OK;
                    rb_next     = 1'b0;
                    k_next      = '0;
                    init_next   = 1'b0;
                    if (idx_bad) begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end else begin
                        case (item.op)
                            OP_INIT:       state_next = S_FILL;
                            OP_LOAD:
                            begin
                                cnt_we     = 1'b1;
                                cnt_wa     = item.entry_index;
                                cnt_wd     = COUNT_BITS'(item.load_value);
                                state_next = item.last_load ? S_INIT : S_DONE;
                            end
                            OP_OBSERVE:    state_next = S_OBS;
                            OP_READ_DIST:  state_next = S_RDCUM;
                            OP_READ_TABLE: state_next = S_RDDEC;
                            default:       state_next = S_DONE;
                        endcase
                    end
                end
            end

            // Uniform init: counts of the alphabet to one.
            S_FILL:
            begin
                cnt_we = 1'b1;
                k_next = k_reg + ALPHA_BITS'(1);
                if (last_k) begin
                    state_next = S_INIT;
                end
            end

            S_INIT:
            begin
                total_next = '0;
                cycle_next = CYC_BITS'(n);
                init_next  = 1'b1;
                state_next = S_ADD;
            end

            // Add the update cycle; halve counts past the maximum total.
            S_ADD:
            begin
                rb_next = 1'b1;
                k_next  = '0;
                if (add_total > TOTAL_BITS'(MAX_TOTAL)) begin
                    total_next = '0;
                    state_next = S_HRD;
                end else begin
                    total_next = add_total;
                    state_next = S_DIVST;
                end
            end

            S_HRD:
            begin
                state_next = S_HWR;
            end

            S_HWR:
            begin
                cnt_we     = 1'b1;
                cnt_wd     = half[COUNT_BITS-1:0];
                total_next = total_reg + TOTAL_BITS'(half);
                k_next     = k_reg + ALPHA_BITS'(1);
                state_next = last_k ? S_DIVST : S_HRD;
            end

            // Scale factor from the serial divider.
            S_DIVST:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end

            S_DIVW:
            begin
                if (div_done) begin
                    scale_next = div_q;
                    sum_next   = '0;
                    k_next     = '0;
                    s_next     = '0;
                    state_next = S_CRD;
                end
            end

            // Cumulative pass: read count, multiply, write entry.
            S_CRD:
            begin
                state_next = S_CMUL;
            end

            S_CMUL:
            begin
                prod_next  = scale_reg * sum_reg;
                sum_next   = sum_reg + TOTAL_BITS'(cnt_q_reg);
                state_next = S_CWR;
            end

            S_CWR:
            begin
                cum_we = 1'b1;
                if (d_shift > TOTAL_BITS'(tsize) + TOTAL_BITS'(1)) begin
                    w_next = tsize + DEC_BITS'(1);
                end else begin
                    w_next = d_shift[DEC_BITS-1:0];
                end
                if (use_table && (s_reg < w_next)) begin
                    state_next = S_TFILL;
                end else if (last_k) begin
                    state_next = use_table ? S_TAIL0 : S_CYC;
                end else begin
                    k_next     = k_reg + ALPHA_BITS'(1);
                    state_next = S_CRD;
                end
            end

            // Decoder entries up to this symbol's position.
            S_TFILL:
            begin
                dec_we = 1'b1;
                s_next = s_reg + DEC_BITS'(1);
                if (s_next == w_reg) begin
                    if (last_k) begin
                        state_next = S_TAIL0;
                    end else begin
                        k_next     = k_reg + ALPHA_BITS'(1);
                        state_next = S_CRD;
                    end
                end
            end

            S_TAIL0:
            begin
                dec_we     = 1'b1;
                dec_wa     = '0;
                dec_wd     = '0;
                state_next = (s_reg <= tsize) ? S_TAIL : S_CYC;
            end

            // Remaining decoder entries point at the last symbol.
            S_TAIL:
            begin
                dec_we = 1'b1;
                dec_wd = n_last[SYM_BITS-1:0];
                s_next = s_reg + DEC_BITS'(1);
                if (s_next > tsize) begin
                    state_next = S_CYC;
                end
            end

            // Set or grow the update cycle and restart the countdown.
            S_CYC:
            begin
                if (init_reg) begin
                    cycle_next = CYC_BITS'((n + ALPHA_BITS'(6)) >> 1);
                end else if (cyc5 > 18'(cyc_cap)) begin
                    cycle_next = cyc_cap;
                end else begin
                    cycle_next = cyc5[CYC_BITS-1:0];
                end
                cdown_next = cycle_next;
                state_next = S_DONE;
            end

            // Bump the observed count, saturating.
            S_OBS:
            begin
                cnt_we = 1'b1;
                cnt_wa = item_reg.entry_index;
                if (cnt_q_reg >= COUNT_MAX) begin
                    cnt_wd      = COUNT_MAX;
                    status_next = ST_SAT;
                end else begin
                    cnt_wd = cnt_q_reg + COUNT_BITS'(1);
                end
                if (cdown_reg <= CYC_BITS'(1)) begin
                    state_next = S_ADD;
                end else begin
                    cdown_next = cdown_reg - CYC_BITS'(1);
                    state_next = S_DONE;
                end
            end

            S_RDCUM:
            begin
                data_next  = tab_q_reg;
                state_next = S_DONE;
            end

            S_RDDEC:
            begin
                data_next  = tab_q_reg;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall) begin
                    out_valid_next    = 1'b1;
                    out_next.read_data = data_reg;
                    out_next.status    = status_reg;
                    out_next.rebuilt   = rb_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            k_reg         <= '0;
            s_reg         <= '0;
            total_reg     <= '0;
            cycle_reg     <= CYC_BITS'(2);
            cdown_reg     <= CYC_BITS'(4);
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            total_reg     <= total_next;
            cycle_reg     <= cycle_next;
            cdown_reg     <= cdown_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        w_reg      <= w_next;
        sum_reg    <= sum_next;
        scale_reg  <= scale_next;
        prod_reg   <= prod_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        rb_reg     <= rb_next;
        out_reg    <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
